>>> rtl/eds_pkg.sv
package eds_pkg;

   // Field widths fixed by the transaction format
   localparam int unsigned TIME_W = 32;
   localparam int unsigned OP_W   = 3;
   localparam int unsigned SRC_W  = 3;
   localparam int unsigned DUE_W  = 5;

   // Operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 3'd0,
      OP_ADVANCE  = 3'd1,
      OP_RESYNC   = 3'd2,
      OP_SCHEDULE = 3'd3,
      OP_CHECK    = 3'd4,
      OP_REBASE   = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [SRC_W-1:0]         source;
      logic signed [TIME_W-1:0] cycles;
   } req_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] elapsed;
      logic                     elapsed_negative;
      logic [DUE_W-1:0]         due_mask;
      logic signed [TIME_W-1:0] earliest_deadline;
   } rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OP,
      ST_SCHED_MIN,
      ST_CHECK_SRC,
      ST_REBASE_SYNC,
      ST_REBASE_DEAD
   } state_type;

   // One step of work for the shared arithmetic unit
   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_CLEAR,
      STEP_ADVANCE,
      STEP_RESYNC,
      STEP_SCHED_WRITE,
      STEP_MIN,
      STEP_CHECK_GATE,
      STEP_CHECK_SRC,
      STEP_REBASE_EARLY,
      STEP_REBASE_SYNC,
      STEP_REBASE_DEAD
   } step_type;

   typedef struct packed {
      step_type step;
      logic     first;
      logic     finish;
   } ctrl_type;

endpackage

>>> rtl/event_deadline_scheduler.sv
// Channel   Ports                        Handshake
// request   start, busy, req (req_type)  taken when start is high and busy is low
// response  rsp_valid, rsp (rsp_type)    one-cycle strobe, always taken
//
// Clear, advance, resync, unused codes and schedule of an absent source finish in the
// op state; schedule and check then sweep every source once, and rebase sweeps them
// twice, first the sync times and then the deadlines.
// All steps but clear use the single shared 32-bit adder/comparator, one source per cycle.
// Busy falls as the response strobe rises, so the next request may be taken in that cycle.
// Synchronous active-high reset returns all times to zero; the receiver cannot stall.
module event_deadline_scheduler #(
   parameter int NUM_SOURCES = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  eds_pkg::req_type req,
   output logic             rsp_valid,
   output eds_pkg::rsp_type rsp
);

   localparam int IDX_W = $clog2(NUM_SOURCES);
   localparam int TW    = eds_pkg::TIME_W;

   eds_pkg::ctrl_type ctrl;
   logic [IDX_W-1:0]  idx;
   logic              accept;

   // Scheduler state
   logic [TW-1:0] time_ff, time_in;
   logic [TW-1:0] earliest_ff, earliest_in;
   logic [TW-1:0] sync_ff [NUM_SOURCES];
   logic [TW-1:0] dead_ff [NUM_SOURCES];

   // Latched request and result fields
   logic [IDX_W-1:0] src_ff;
   logic [TW-1:0]    cyc_ff;
   logic [TW-1:0]    elapsed_ff, elapsed_in;
   logic             neg_ff, neg_in;
   logic [eds_pkg::DUE_W-1:0] mask_ff, mask_in;
   logic             gate_ff, gate_in;
   logic             rsp_valid_ff;

   // Shared unit operands
   logic [IDX_W-1:0] rd_idx;
   logic [TW-1:0]    sync_rd, dead_rd;
   logic [TW-1:0]    alu_a, alu_b, alu_sum;
   logic             alu_sub, alu_less;

   assign accept = start && !busy;

   eds_ctrl #(
      .NUM_SOURCES (NUM_SOURCES),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req),
      .busy  (busy),
      .ctrl  (ctrl),
      .idx   (idx)
   );

   eds_alu u_alu (
      .a    (alu_a),
      .b    (alu_b),
      .sub  (alu_sub),
      .sum  (alu_sum),
      .less (alu_less)
   );

   // Read the source named by the request for resync, else the sweep entry
   assign rd_idx  = (ctrl.step == eds_pkg::STEP_RESYNC) ? src_ff : idx;
   assign sync_rd = sync_ff[rd_idx];
   assign dead_rd = dead_ff[rd_idx];

   // Select operands for the current step
   always_comb begin
      alu_a   = time_ff;
      alu_b   = cyc_ff;
      alu_sub = 1'b1;
      unique case (ctrl.step)
         eds_pkg::STEP_ADVANCE,
         eds_pkg::STEP_SCHED_WRITE: begin
            alu_sub = 1'b0;
         end
         eds_pkg::STEP_RESYNC:       alu_b = sync_rd;
         eds_pkg::STEP_MIN: begin
            alu_a = dead_rd;
            alu_b = earliest_ff;
         end
         eds_pkg::STEP_CHECK_GATE:   alu_b = earliest_ff;
         eds_pkg::STEP_CHECK_SRC:    alu_b = dead_rd;
         eds_pkg::STEP_REBASE_EARLY: begin
            alu_a = earliest_ff;
            alu_b = time_ff;
         end
         eds_pkg::STEP_REBASE_SYNC: begin
            alu_a = sync_rd;
            alu_b = time_ff;
         end
         eds_pkg::STEP_REBASE_DEAD: begin
            alu_a = dead_rd;
            alu_b = time_ff;
         end
         default: begin
            alu_a = time_ff;
         end
      endcase
   end

   // Next values of scalar state and result fields
   always_comb begin
      time_in     = time_ff;
      earliest_in = earliest_ff;
      elapsed_in  = elapsed_ff;
      neg_in      = neg_ff;
      mask_in     = mask_ff;
      gate_in     = gate_ff;
      if (accept) begin
         elapsed_in = '0;
         neg_in     = 1'b0;
         mask_in    = '0;
      end
      unique case (ctrl.step)
         eds_pkg::STEP_CLEAR: begin
            time_in     = '0;
            earliest_in = '0;
         end
         eds_pkg::STEP_ADVANCE:    time_in = alu_sum;
         eds_pkg::STEP_RESYNC: begin
            elapsed_in = alu_sum;
            neg_in     = alu_sum[TW-1];
         end
         eds_pkg::STEP_MIN: begin
            if (ctrl.first || alu_less) begin
               earliest_in = dead_rd;
            end
         end
         eds_pkg::STEP_CHECK_GATE: gate_in = !alu_less;
         eds_pkg::STEP_CHECK_SRC: begin
            for (int k = 0; k < eds_pkg::DUE_W; k++) begin
               if ((k < NUM_SOURCES) && (idx == IDX_W'(k)) && gate_ff && !alu_less) begin
                  mask_in[k] = 1'b1;
               end
            end
         end
         eds_pkg::STEP_REBASE_EARLY: earliest_in = alu_sum;
         eds_pkg::STEP_REBASE_DEAD: begin
            if (ctrl.finish) begin
               time_in = '0;
            end
         end
         default: begin
            time_in = time_ff;
         end
      endcase
   end

   // Hold scalar state, results and the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         earliest_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         gate_ff      <= 1'b0;
      end else begin
         time_ff      <= time_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= ctrl.finish;
         gate_ff      <= gate_in;
      end
   end

   // Latch the request fields and result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         src_ff <= IDX_W'(req.source);
         cyc_ff <= req.cycles;
      end
      elapsed_ff <= elapsed_in;
      neg_ff     <= neg_in;
      mask_ff    <= mask_in;
   end

   // Update per-source times
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            sync_ff[i] <= '0;
            dead_ff[i] <= '0;
         end
      end else begin
         unique case (ctrl.step)
            eds_pkg::STEP_CLEAR: begin
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  sync_ff[i] <= '0;
                  dead_ff[i] <= '0;
               end
            end
            eds_pkg::STEP_RESYNC:      sync_ff[src_ff] <= time_ff;
            eds_pkg::STEP_SCHED_WRITE: dead_ff[src_ff] <= alu_sum;
            eds_pkg::STEP_REBASE_SYNC: sync_ff[idx]    <= alu_sum;
            eds_pkg::STEP_REBASE_DEAD: dead_ff[idx]    <= alu_sum;
            default: begin
            end
         endcase
      end
   end

   // Drive the response
   assign rsp_valid             = rsp_valid_ff;
   assign rsp.elapsed           = elapsed_ff;
   assign rsp.elapsed_negative  = neg_ff;
   assign rsp.due_mask          = mask_ff;
   assign rsp.earliest_deadline = earliest_ff;

endmodule

>>> rtl/eds_alu.sv
module eds_alu (
   input  logic [eds_pkg::TIME_W-1:0] a,
   input  logic [eds_pkg::TIME_W-1:0] b,
   input  logic                       sub,
   output logic [eds_pkg::TIME_W-1:0] sum,
   output logic                       less
);

   // Add or subtract on one wrapping adder
   assign sum = a + (b ^ {eds_pkg::TIME_W{sub}}) + eds_pkg::TIME_W'(sub);

   // Signed a < b from the difference; valid when sub is set
   assign less = (a[eds_pkg::TIME_W-1] != b[eds_pkg::TIME_W-1]) ?
                 a[eds_pkg::TIME_W-1] : sum[eds_pkg::TIME_W-1];

endmodule

>>> rtl/eds_ctrl.sv
module eds_ctrl #(
   parameter int NUM_SOURCES = 5,
   parameter int IDX_W       = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  eds_pkg::req_type     req,
   output logic                 busy,
   output eds_pkg::ctrl_type    ctrl,
   output logic [IDX_W-1:0]     idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

   eds_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [eds_pkg::OP_W-1:0] op_ff, op_in;
   logic               src_ok_ff, src_ok_in;
   logic               accept;

   assign accept = start && (state_ff == eds_pkg::ST_IDLE);
   assign busy   = (state_ff != eds_pkg::ST_IDLE);
   assign idx    = idx_ff;

   // Hold state, sweep index and the latched operation
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= eds_pkg::ST_IDLE;
         idx_ff    <= '0;
         op_ff     <= '0;
         src_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         op_ff     <= op_in;
         src_ok_ff <= src_ok_in;
      end
   end

   // Sequence the steps of each operation
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      src_ok_in   = src_ok_ff;
      ctrl.step   = eds_pkg::STEP_NONE;
      ctrl.first  = (idx_ff == '0);
      ctrl.finish = 1'b0;
      unique case (state_ff)
         eds_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = req.op;
               src_ok_in = (32'(req.source) < NUM_SOURCES);
               idx_in    = '0;
               state_in  = eds_pkg::ST_OP;
            end
         end
         eds_pkg::ST_OP: begin
            idx_in = '0;
            unique case (op_ff)
               eds_pkg::OP_CLEAR: begin
                  ctrl.step   = eds_pkg::STEP_CLEAR;
                  ctrl.finish = 1'b1;
                  state_in    = eds_pkg::ST_IDLE;
               end
               eds_pkg::OP_ADVANCE: begin
                  ctrl.step   = eds_pkg::STEP_ADVANCE;
                  ctrl.finish = 1'b1;
                  state_in    = eds_pkg::ST_IDLE;
               end
               eds_pkg::OP_RESYNC: begin
                  if (src_ok_ff) begin
                     ctrl.step = eds_pkg::STEP_RESYNC;
                  end
                  ctrl.finish = 1'b1;
                  state_in    = eds_pkg::ST_IDLE;
               end
               eds_pkg::OP_SCHEDULE: begin
                  if (src_ok_ff) begin
                     ctrl.step = eds_pkg::STEP_SCHED_WRITE;
                     state_in  = eds_pkg::ST_SCHED_MIN;
                  end else begin
                     ctrl.finish = 1'b1;
                     state_in    = eds_pkg::ST_IDLE;
                  end
               end
               eds_pkg::OP_CHECK: begin
                  ctrl.step = eds_pkg::STEP_CHECK_GATE;
                  state_in  = eds_pkg::ST_CHECK_SRC;
               end
               eds_pkg::OP_REBASE: begin
                  ctrl.step = eds_pkg::STEP_REBASE_EARLY;
                  state_in  = eds_pkg::ST_REBASE_SYNC;
               end
               default: begin
                  ctrl.finish = 1'b1;
                  state_in    = eds_pkg::ST_IDLE;
               end
            endcase
         end
         eds_pkg::ST_SCHED_MIN: begin
            ctrl.step = eds_pkg::STEP_MIN;
            if (idx_ff == LAST_IDX) begin
               ctrl.finish = 1'b1;
               state_in    = eds_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         eds_pkg::ST_CHECK_SRC: begin
            ctrl.step = eds_pkg::STEP_CHECK_SRC;
            if (idx_ff == LAST_IDX) begin
               ctrl.finish = 1'b1;
               state_in    = eds_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         eds_pkg::ST_REBASE_SYNC: begin
            ctrl.step = eds_pkg::STEP_REBASE_SYNC;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = eds_pkg::ST_REBASE_DEAD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         eds_pkg::ST_REBASE_DEAD: begin
            ctrl.step = eds_pkg::STEP_REBASE_DEAD;
            if (idx_ff == LAST_IDX) begin
               ctrl.finish = 1'b1;
               state_in    = eds_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = eds_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> test/event_deadline_scheduler_tb.sv
`timescale 1ns / 100ps

module event_deadline_scheduler_tb;

   localparam int NUM_SOURCES    = 5;
   localparam int SRC_MAX        = (1 << eds_pkg::SRC_W) - 1;
   localparam int ITEMS_PER_RUN  = 500;
   localparam int MAX_GAP        = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 2 * NUM_SOURCES + 8;

   // Op codes the block does not define; they must leave all state alone
   localparam logic [eds_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [eds_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic signed [eds_pkg::TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
   localparam logic signed [eds_pkg::TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;

   // Tracks the scheduler state and the responses still owed by the block
   class deadline_scoreboard;
      logic signed [eds_pkg::TIME_W-1:0] now_time;
      logic signed [eds_pkg::TIME_W-1:0] sync_time [NUM_SOURCES];
      logic signed [eds_pkg::TIME_W-1:0] due_time [NUM_SOURCES];
      logic signed [eds_pkg::TIME_W-1:0] earliest;
      eds_pkg::rsp_type                  expected_rsp_q [$];
      int                                errors;
      int                                checked;
      int                                op_count [8];
      int                                due_hits;
      int                                negative_hits;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         now_time = '0;
         earliest = '0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            sync_time[i] = '0;
            due_time[i]  = '0;
         end
      endfunction

      // Apply one accepted transaction and queue the response it must produce
      function void note_request(eds_pkg::req_type item);
         eds_pkg::rsp_type want;
         want = '0;
         op_count[item.op]++;
         case (item.op)
            eds_pkg::OP_CLEAR: begin
               clear_state();
            end
            eds_pkg::OP_ADVANCE: begin
               now_time = now_time + item.cycles;
            end
            eds_pkg::OP_RESYNC: begin
               if (item.source < NUM_SOURCES) begin
                  want.elapsed          = now_time - sync_time[item.source];
                  want.elapsed_negative = want.elapsed[eds_pkg::TIME_W-1];
                  sync_time[item.source] = now_time;
               end
            end
            eds_pkg::OP_SCHEDULE: begin
               if (item.source < NUM_SOURCES) begin
                  due_time[item.source] = now_time + item.cycles;
                  earliest = due_time[0];
                  for (int i = 1; i < NUM_SOURCES; i++)
                     if (due_time[i] < earliest) earliest = due_time[i];
               end
            end
            eds_pkg::OP_CHECK: begin
               // nothing is due while the earliest deadline lies ahead
               if (!(now_time < earliest)) begin
                  for (int i = 0; i < NUM_SOURCES && i < eds_pkg::DUE_W; i++)
                     if (!(now_time < due_time[i])) want.due_mask[i] = 1'b1;
               end
            end
            eds_pkg::OP_REBASE: begin
               // shift every time by the timestamp; earliest is shifted, not recomputed
               for (int i = 0; i < NUM_SOURCES; i++) begin
                  sync_time[i] = sync_time[i] - now_time;
                  due_time[i]  = due_time[i] - now_time;
               end
               earliest = earliest - now_time;
               now_time = '0;
            end
            default: begin
            end
         endcase
         want.earliest_deadline = earliest;
         if (want.due_mask != '0) due_hits++;
         if (want.elapsed_negative) negative_hits++;
         expected_rsp_q.push_back(want);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // Compare one response with the oldest outstanding expectation
      task check_response(eds_pkg::rsp_type got);
         eds_pkg::rsp_type want;
         checked++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing outstanding: %h",
                                      checked, got));
            return;
         end
         want = expected_rsp_q.pop_front();
         if (got.elapsed !== want.elapsed)
            report_mismatch($sformatf("response %0d elapsed %h, expected %h",
                                      checked, got.elapsed, want.elapsed));
         if (got.elapsed_negative !== want.elapsed_negative)
            report_mismatch($sformatf("response %0d elapsed_negative %b, expected %b",
                                      checked, got.elapsed_negative, want.elapsed_negative));
         if (got.due_mask !== want.due_mask)
            report_mismatch($sformatf("response %0d due_mask %b, expected %b",
                                      checked, got.due_mask, want.due_mask));
         if (got.earliest_deadline !== want.earliest_deadline)
            report_mismatch($sformatf("response %0d earliest_deadline %h, expected %h",
                                      checked, got.earliest_deadline,
                                      want.earliest_deadline));
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   eds_pkg::req_type req;
   logic             rsp_valid;
   eds_pkg::rsp_type rsp;

   deadline_scoreboard sb = new();
   int idle_cycles;

   event_deadline_scheduler #(
      .NUM_SOURCES(NUM_SOURCES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check every response strobe against the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) sb.check_response(rsp);
   end

   // Abort when the handshakes stop moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   function automatic eds_pkg::req_type make_req(logic [eds_pkg::OP_W-1:0] op, int src,
                                                 logic signed [eds_pkg::TIME_W-1:0] cyc);
      eds_pkg::req_type item;
      item.op     = op;
      item.source = src[eds_pkg::SRC_W-1:0];
      item.cycles = cyc;
      return item;
   endfunction

   // Mostly valid sources and short time steps so that deadlines are actually reached
   function automatic eds_pkg::req_type random_request();
      eds_pkg::req_type item;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 24)      item.op = eds_pkg::OP_ADVANCE;
      else if (pick < 40) item.op = eds_pkg::OP_RESYNC;
      else if (pick < 66) item.op = eds_pkg::OP_SCHEDULE;
      else if (pick < 88) item.op = eds_pkg::OP_CHECK;
      else if (pick < 94) item.op = eds_pkg::OP_REBASE;
      else if (pick < 97) item.op = eds_pkg::OP_CLEAR;
      else item.op = eds_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if ($urandom_range(99) < 88)
         item.source = eds_pkg::SRC_W'($urandom_range(NUM_SOURCES - 1));
      else
         item.source = eds_pkg::SRC_W'($urandom_range(SRC_MAX, NUM_SOURCES));
      pick = $urandom_range(99);
      if (pick < 65) begin
         item.cycles = $signed($urandom_range(96)) - 16;
      end else if (pick < 90) begin
         item.cycles = $urandom;
      end else begin
         case ($urandom_range(3))
            0:       item.cycles = TIME_MIN;
            1:       item.cycles = TIME_MAX;
            2:       item.cycles = '0;
            default: item.cycles = '1;
         endcase
      end
      return item;
   endfunction

   // Hold start high until the transaction is taken; keep it high for a back-to-back one
   task automatic send_request(eds_pkg::req_type item, int idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req   <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(item);
   endtask

   initial begin
      int idle_pct;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, wrap-around, extremes, out-of-range sources, spare ops
      send_request(make_req(eds_pkg::OP_CHECK, 0, '0), 0);
      send_request(make_req(eds_pkg::OP_RESYNC, 0, '0), 0);
      send_request(make_req(eds_pkg::OP_ADVANCE, 0, TIME_MAX), 0);
      send_request(make_req(eds_pkg::OP_ADVANCE, 3, 32'sd1), 0);
      send_request(make_req(eds_pkg::OP_RESYNC, 1, '0), 0);
      send_request(make_req(eds_pkg::OP_SCHEDULE, 4, TIME_MIN), 0);
      send_request(make_req(eds_pkg::OP_SCHEDULE, 2, TIME_MAX), 0);
      send_request(make_req(eds_pkg::OP_SCHEDULE, SRC_MAX, '1), 0);
      send_request(make_req(eds_pkg::OP_RESYNC, NUM_SOURCES, '1), 0);
      send_request(make_req(eds_pkg::OP_CHECK, 7, TIME_MAX), 0);
      send_request(make_req(OP_SPARE_LO, SRC_MAX, '1), 0);
      send_request(make_req(OP_SPARE_HI, 0, TIME_MIN), 0);
      send_request(make_req(eds_pkg::OP_REBASE, 0, '0), 0);
      send_request(make_req(eds_pkg::OP_CHECK, 0, '0), 0);
      for (int i = 0; i < NUM_SOURCES; i++)
         send_request(make_req(eds_pkg::OP_SCHEDULE, i, 32'sd3 * i - 2), 0);
      send_request(make_req(eds_pkg::OP_ADVANCE, 0, 32'sd5), 0);
      send_request(make_req(eds_pkg::OP_CHECK, 0, '0), 0);
      send_request(make_req(eds_pkg::OP_RESYNC, 3, '0), 0);
      send_request(make_req(eds_pkg::OP_CLEAR, SRC_MAX, '1), 0);
      send_request(make_req(eds_pkg::OP_CHECK, 0, '0), 0);

      // Random: light sender gaps, then heavy gaps, then back-to-back
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 33 : (phase == 1) ? 69 : 0;
         repeat (ITEMS_PER_RUN / 3) send_request(random_request(), idle_pct);
      end
      start <= 1'b0;

      // Drain outstanding responses, then allow for anything spurious
      while (sb.expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_rsp_q.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.expected_rsp_q.size()));

      $display("covered %0d transactions: %0d advance, %0d resync, %0d schedule, %0d check",
               sb.checked, sb.op_count[eds_pkg::OP_ADVANCE], sb.op_count[eds_pkg::OP_RESYNC],
               sb.op_count[eds_pkg::OP_SCHEDULE], sb.op_count[eds_pkg::OP_CHECK]);
      $display("  %0d rebase, %0d clear, %0d spare ops; %0d checks with sources due, %0d negative",
               sb.op_count[eds_pkg::OP_REBASE], sb.op_count[eds_pkg::OP_CLEAR],
               sb.op_count[OP_SPARE_LO] + sb.op_count[OP_SPARE_HI],
               sb.due_hits, sb.negative_hits);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/eds_pkg.sv
rtl/eds_alu.sv
rtl/eds_ctrl.sv
rtl/event_deadline_scheduler.sv
test/event_deadline_scheduler_tb.sv
